// ----- hdl/ptr_pkg.sv -----
// ptr_pkg: shared types and constants for the perceptron trainer
// no dependencies; used by the channel interfaces, the weight cell and the top level
package ptr_pkg;

  // command opcodes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_LOAD_WEIGHT = 2'd0;
  localparam opcode_t OP_LOAD_SAMPLE = 2'd1;
  localparam opcode_t OP_TRAIN       = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_RATE     = 2'd0;
  localparam cfg_index_t REG_EPOCHS   = 2'd1;
  localparam cfg_index_t REG_FEATURES = 2'd2;

  // configuration reset values
  localparam logic [15:0] RATE_RESET   = 16'd655;
  localparam logic [11:0] EPOCH_RESET  = 12'd1500;
  localparam logic [4:0]  FEAT_RESET   = 5'd16;

  // field widths
  localparam int IDX_W   = 5;
  localparam int FEAT_W  = 16;
  localparam int COUNT_W = 11;

  typedef logic signed [31:0]       weight_t;
  typedef logic signed [FEAT_W-1:0] feature_t;

endpackage

// ----- hdl/ptr_channels.sv -----
// ptr_cmd_if and ptr_res_if: valid/ready channels for commands and trained results
// depends on ptr_pkg

interface ptr_cmd_if;
  logic               valid;
  logic               ready;
  ptr_pkg::opcode_t   opcode;
  logic [4:0]         weight_index;
  ptr_pkg::weight_t   weight_value;
  ptr_pkg::feature_t  feature_value;
  ptr_pkg::feature_t  label;
  logic               end_of_row;

  modport source (output valid, opcode, weight_index, weight_value, feature_value, label,
                  end_of_row, input ready);
  modport sink   (input valid, opcode, weight_index, weight_value, feature_value, label,
                  end_of_row, output ready);
endinterface

interface ptr_res_if;
  logic               valid;
  logic               ready;
  logic [4:0]         slot_index;
  ptr_pkg::weight_t   trained_value;
  logic [10:0]        error_count;
  logic [10:0]        row_total;
  logic               last;

  modport source (output valid, slot_index, trained_value, error_count, row_total, last,
                  input ready);
  modport sink   (input valid, slot_index, trained_value, error_count, row_total, last,
                  output ready);
endinterface

// ----- hdl/ptr_cell.sv -----
// ptr_cell: one weight of the rotating weight chain
// depends on ptr_pkg
module ptr_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             load,
  input  ptr_pkg::weight_t load_value,
  input  ptr_pkg::weight_t next_in,
  output ptr_pkg::weight_t value
);

  // direct load by index, otherwise take the neighbor's weight on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (load) begin
      value <= load_value;
    end else if (shift) begin
      value <= next_in;
    end
  end

endmodule

// ----- hdl/perceptron_trainer.sv -----
// perceptron_trainer: perceptron training engine built on a rotating chain of weight cells
// depends on ptr_pkg, ptr_channels (ptr_cmd_if, ptr_res_if) and ptr_cell
//
//   channel | dir | beat carries
//   --------+-----+---------------------------------------------------------------
//   cmd     | in  | opcode, weight_index, weight_value, feature_value, label, end_of_row
//   res     | out | slot_index, trained_value, error_count, row_total, last
//   cfg_*   | in  | write enable, register index, data (no handshake)
//
// load beats are taken only while idle. a train beat runs each row as a dot pass, plus
// an update pass when the row is misclassified, each reading the single sample memory
// read port once per column while the weight chain turns; then one counting pass of dot
// passes, one result beat per cycle while res is ready, and, when not all columns are in
// use, a rewind of the chain to weight zero at the head. reset is synchronous and needs
// no clearing pass. cmd is held off while a train command runs; res stalls only the emitter.
module perceptron_trainer #(
  parameter int MAX_FEATURES = 16,
  parameter int MAX_ROWS     = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  ptr_cmd_if.sink                   cmd,
  ptr_res_if.source                 res,
  input  logic                      cfg_we,
  input  ptr_pkg::cfg_index_t       cfg_index,
  input  logic [ptr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_FEATURES * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CPW   = $clog2(MAX_FEATURES + 1);
  localparam int KW    = $clog2(MAX_FEATURES + 3);
  localparam int ACC_W = 56;

  typedef enum logic [2:0] {S_IDLE, S_DOT, S_UPD, S_EMIT, S_REWIND} state_t;

  state_t state;

  // configuration
  logic [15:0] learning_rate;
  logic [11:0] epoch_count;
  logic [4:0]  feature_count;

  // stored model and data
  ptr_pkg::weight_t  w [MAX_FEATURES];
  ptr_pkg::weight_t  bias;
  ptr_pkg::feature_t sample_mem [DEPTH];
  ptr_pkg::feature_t label_mem [MAX_ROWS];
  ptr_pkg::feature_t x_rd;
  ptr_pkg::feature_t lab_rd;
  logic [RW-1:0]     row_count;
  logic [CPW-1:0]    col_ptr;
  logic [AW-1:0]     wr_base;

  // sequencer
  logic [RIW-1:0] row_i;
  logic [AW-1:0]  rd_base;
  logic [KW-1:0]  k;
  logic [CPW-1:0] cols;
  logic [11:0]    epoch_n;
  logic           counting;
  logic [RW-1:0]  errs;
  logic [CPW-1:0] j_out;
  logic [CPW-1:0] rot;

  // datapath pipeline
  logic                     s1_v;
  logic [CPW-1:0]           s1_col;
  logic                     s2_v;
  logic signed [47:0]       prod;
  logic signed [48:0]       step;
  logic signed [32:0]       rl;
  logic signed [ACC_W-1:0]  acc;

  // output register
  logic                     res_valid;
  logic [4:0]               res_slot;
  ptr_pkg::weight_t         res_value;
  logic [10:0]              res_errs;
  logic [10:0]              res_rows;
  logic                     res_last;

  logic             cmd_fire;
  logic             emit_slot;
  logic             ring_shift;
  ptr_pkg::weight_t head_new;
  logic signed [48:0] st_t;
  logic signed [32:0] bt_t;
  ptr_pkg::weight_t step_d;
  ptr_pkg::weight_t bias_d;
  logic             wrong;
  logic             k_end;
  logic             row_end;
  logic             last_row;
  logic [AW-1:0]    rd_addr;

  function automatic ptr_pkg::weight_t sat_add(input ptr_pkg::weight_t a,
                                               input ptr_pkg::weight_t d);
    logic signed [32:0] r;
    r = 33'(a) + 33'(d);
    if (r[32] != r[31]) begin
      return r[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r[31:0];
  endfunction

  // handshakes
  assign cmd.ready  = (state == S_IDLE);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign emit_slot  = (state == S_EMIT) && (!res_valid || res.ready);

  assign res.valid         = res_valid;
  assign res.slot_index    = res_slot;
  assign res.trained_value = res_value;
  assign res.error_count   = res_errs;
  assign res.row_total     = res_rows;
  assign res.last          = res_last;

  // rounded steps, nearest with ties upward
  assign st_t   = step + 49'sd8388608;
  assign step_d = 32'($signed(st_t[48:24]));
  assign bt_t   = rl + 33'sd2048;
  assign bias_d = 32'($signed(bt_t[32:12]));

  // chain control
  always_comb begin
    ring_shift = 1'b0;
    head_new   = w[0];
    case (state)
      S_DOT:    ring_shift = s1_v;
      S_UPD: begin
        ring_shift = s2_v;
        head_new   = sat_add(w[0], step_d);
      end
      S_EMIT:   ring_shift = emit_slot && (j_out < cols);
      S_REWIND: ring_shift = 1'b1;
      default:  ring_shift = 1'b0;
    endcase
  end

  // weight cells
  for (genvar c = 0; c < MAX_FEATURES; c++) begin : g_cell
    ptr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (ring_shift),
      .load       (cmd_fire && cmd.opcode == ptr_pkg::OP_LOAD_WEIGHT &&
                   32'(cmd.weight_index) == c),
      .load_value (cmd.weight_value),
      .next_in    ((c == MAX_FEATURES - 1) ? head_new : w[(c + 1) % MAX_FEATURES]),
      .value      (w[c])
    );
  end

  // row decisions
  assign k_end    = (k == KW'(MAX_FEATURES + 2));
  assign wrong    = (lab_rd == '0) || (acc == '0) || (lab_rd[15] != acc[ACC_W-1]);
  assign row_end  = ((state == S_DOT) && k_end && !(wrong && !counting)) ||
                    ((state == S_UPD) && k_end);
  assign last_row = (RW'(row_i) + RW'(1)) == row_count;
  assign rd_addr  = rd_base + AW'(k);

  // sample and label stores
  always_ff @(posedge clk) begin
    if (cmd_fire && cmd.opcode == ptr_pkg::OP_LOAD_SAMPLE && row_count < RW'(MAX_ROWS)) begin
      if (col_ptr < CPW'(MAX_FEATURES)) begin
        sample_mem[wr_base + AW'(col_ptr)] <= cmd.feature_value;
      end
      if (cmd.end_of_row) begin
        label_mem[row_count[RIW-1:0]] <= cmd.label;
      end
    end
    x_rd   <= sample_mem[rd_addr];
    lab_rd <= label_mem[row_i];
  end

  // multipliers
  always_ff @(posedge clk) begin
    if (state == S_DOT) begin
      prod <= (s1_col < cols) ? 48'(w[0]) * 48'(x_rd) : '0;
    end
    if (state == S_UPD) begin
      step <= (s1_col < cols) ? 49'(rl) * 49'(x_rd) : '0;
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      learning_rate <= ptr_pkg::RATE_RESET;
      epoch_count   <= ptr_pkg::EPOCH_RESET;
      feature_count <= ptr_pkg::FEAT_RESET;
      bias          <= '0;
      row_count     <= '0;
      col_ptr       <= '0;
      wr_base       <= '0;
      row_i         <= '0;
      rd_base       <= '0;
      k             <= '0;
      cols          <= '0;
      epoch_n       <= '0;
      counting      <= 1'b0;
      errs          <= '0;
      j_out         <= '0;
      rot           <= '0;
      s1_v          <= 1'b0;
      s1_col        <= '0;
      s2_v          <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          ptr_pkg::REG_RATE:     learning_rate <= cfg_data;
          ptr_pkg::REG_EPOCHS:   epoch_count   <= cfg_data[11:0];
          ptr_pkg::REG_FEATURES: feature_count <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end

      // read pipeline valids
      s1_v   <= ((state == S_DOT) || (state == S_UPD)) && (k < KW'(MAX_FEATURES));
      s1_col <= CPW'(k);
      s2_v   <= s1_v;

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (cmd.opcode)
              ptr_pkg::OP_LOAD_WEIGHT: begin
                if (32'(cmd.weight_index) == MAX_FEATURES) begin
                  bias <= cmd.weight_value;
                end
              end
              ptr_pkg::OP_LOAD_SAMPLE: begin
                if (row_count < RW'(MAX_ROWS)) begin
                  if (col_ptr < CPW'(MAX_FEATURES)) begin
                    col_ptr <= col_ptr + CPW'(1);
                  end
                  if (cmd.end_of_row) begin
                    row_count <= row_count + RW'(1);
                    col_ptr   <= '0;
                    wr_base   <= wr_base + AW'(MAX_FEATURES);
                  end
                end
              end
              ptr_pkg::OP_TRAIN: begin
                if (32'(feature_count) > MAX_FEATURES) begin
                  cols <= CPW'(MAX_FEATURES);
                end else begin
                  cols <= CPW'(feature_count);
                end
                row_i    <= '0;
                rd_base  <= '0;
                k        <= '0;
                epoch_n  <= '0;
                errs     <= '0;
                j_out    <= '0;
                counting <= (epoch_count == '0);
                state    <= (row_count == '0) ? S_EMIT : S_DOT;
              end
              default: ;
            endcase
          end
        end

        // dot product of the current row
        S_DOT: begin
          k <= k + KW'(1);
          if (k == '0) begin
            acc <= ACC_W'($signed({bias, 12'b0}));
          end else if (s2_v) begin
            acc <= acc + ACC_W'(prod);
          end
          if (k_end) begin
            k <= '0;
            if (wrong) begin
              if (counting) begin
                errs <= errs + RW'(1);
              end else begin
                rl    <= 33'($signed({1'b0, learning_rate})) * 33'(lab_rd);
                state <= S_UPD;
              end
            end
          end
        end

        // weight update, bias last
        S_UPD: begin
          k <= k + KW'(1);
          if (k_end) begin
            k    <= '0;
            bias <= sat_add(bias, bias_d);
          end
        end

        // one beat per weight, then the bias
        S_EMIT: begin
          if (emit_slot) begin
            res_valid <= 1'b1;
            res_errs  <= ptr_pkg::COUNT_W'(errs);
            res_rows  <= ptr_pkg::COUNT_W'(row_count);
            if (j_out < cols) begin
              res_slot  <= ptr_pkg::IDX_W'(j_out);
              res_value <= w[0];
              res_last  <= 1'b0;
              j_out     <= j_out + CPW'(1);
            end else begin
              res_slot  <= ptr_pkg::IDX_W'(MAX_FEATURES);
              res_value <= bias;
              res_last  <= 1'b1;
              rot       <= cols;
              state     <= (cols == CPW'(MAX_FEATURES)) ? S_IDLE : S_REWIND;
            end
          end
        end

        // turn the chain back to weight zero at the head
        S_REWIND: begin
          rot <= rot + CPW'(1);
          if (rot == CPW'(MAX_FEATURES - 1)) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // advance to the next row, epoch or the counting pass
      if (row_end) begin
        if (last_row) begin
          row_i   <= '0;
          rd_base <= '0;
          state   <= S_DOT;
          if (counting) begin
            j_out <= '0;
            state <= S_EMIT;
          end else if (epoch_n + 12'd1 == epoch_count) begin
            counting <= 1'b1;
          end else begin
            epoch_n <= epoch_n + 12'd1;
          end
        end else begin
          row_i   <= row_i + RIW'(1);
          rd_base <= rd_base + AW'(MAX_FEATURES);
          state   <= S_DOT;
        end
      end
    end
  end

endmodule
